### hw/rtl/tfn_pkg.sv
// Types and constants shared by the triangle face normal pipeline.
// No dependencies; every other file in hw/rtl refers to this package.
package tfn_pkg;

    localparam int unsigned CoordW = 24;
    localparam int unsigned IdxW   = 16;
    localparam int unsigned EdgeW  = CoordW + 1;
    localparam int unsigned ProdW  = 2 * EdgeW;
    localparam int unsigned MagW   = ProdW;
    localparam int unsigned NormW  = 31;
    localparam int unsigned SumW   = 64;
    localparam int unsigned LenW   = 32;
    localparam int unsigned FracW  = 14;
    localparam int unsigned QuotW  = FracW + 1;
    localparam int unsigned NumW   = NormW + FracW + 1;
    localparam int unsigned OutW   = 16;
    localparam logic [QuotW-1:0] UnitOne = QuotW'(16384);

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [IdxW-1:0]          idx_t;
    typedef logic signed [OutW-1:0]   nrm_t;

    // Data that rides along the whole pipeline.
    typedef struct packed {
        idx_t       idx0;
        idx_t       idx1;
        idx_t       idx2;
        logic [2:0] neg;
    } side_t;

    typedef struct packed {
        coord_t p0x, p0y, p0z;
        coord_t p1x, p1y, p1z;
        coord_t p2x, p2y, p2z;
        idx_t   idx0, idx1, idx2;
    } tri_t;

    typedef struct packed {
        side_t                 side;
        logic [2:0][MagW-1:0]  m;
    } mag_t;

    typedef struct packed {
        side_t                 side;
        logic [2:0][NormW-1:0] m;
        logic [SumW-1:0]       s;
    } sq_t;

    typedef struct packed {
        side_t                 side;
        logic [2:0][NormW-1:0] m;
        logic [LenW-1:0]       len;
    } len_t;

    typedef struct packed {
        nrm_t nx, ny, nz;
        logic degenerate;
        idx_t idx0, idx1, idx2;
    } res_t;

endpackage

### hw/rtl/tfn_if.sv
// Channel interfaces for the triangle face normal block: triangle in, normal out.
// Uses tfn_pkg for field types.
interface tfn_tri_if;
    logic            valid;
    logic            ready;
    tfn_pkg::coord_t first_x, first_y, first_z;
    tfn_pkg::coord_t second_x, second_y, second_z;
    tfn_pkg::coord_t third_x, third_y, third_z;
    tfn_pkg::idx_t   first_index, second_index, third_index;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    third_x, third_y, third_z, first_index, second_index, third_index,
                    input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, first_index, second_index, third_index,
                  output ready);
endinterface

interface tfn_nrm_if;
    logic          valid;
    logic          ready;
    tfn_pkg::nrm_t normal_x, normal_y, normal_z;
    logic          degenerate;
    tfn_pkg::idx_t out_first_index, out_second_index, out_third_index;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                    out_first_index, out_second_index, out_third_index, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
                  out_first_index, out_second_index, out_third_index, output ready);
endinterface

### hw/rtl/tfn_cross.sv
// Edge vectors, partial products and exact cross product magnitudes: three stages.
// Uses tfn_pkg.
module tfn_cross (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  tfn_pkg::tri_t in_data,
    output logic          out_valid,
    output tfn_pkg::mag_t out_data
);
    localparam int unsigned EW = tfn_pkg::EdgeW;
    localparam int unsigned PW = tfn_pkg::ProdW;

    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] pr_reg [6];
    tfn_pkg::side_t       s1_reg, s2_reg;
    tfn_pkg::mag_t        s3_reg;
    logic [2:0]           v_reg;
    logic signed [PW:0]   c [3];
    tfn_pkg::mag_t        s3_next;

    // Take each component's sign and magnitude
    always_comb
    begin
        s3_next      = '0;
        s3_next.side = s2_reg;
        c[0] = {pr_reg[0][PW-1], pr_reg[0]} - {pr_reg[1][PW-1], pr_reg[1]};
        c[1] = {pr_reg[2][PW-1], pr_reg[2]} - {pr_reg[3][PW-1], pr_reg[3]};
        c[2] = {pr_reg[4][PW-1], pr_reg[4]} - {pr_reg[5][PW-1], pr_reg[5]};
        for (int i = 0; i < 3; i++)
        begin
            s3_next.side.neg[i] = c[i][PW];
            s3_next.m[i] = c[i][PW] ? tfn_pkg::MagW'(-c[i]) : tfn_pkg::MagW'(c[i]);
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], in_valid};
    end

    // Advance the data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg[0] <= {in_data.p1x[23], in_data.p1x} - {in_data.p0x[23], in_data.p0x};
            e1_reg[1] <= {in_data.p1y[23], in_data.p1y} - {in_data.p0y[23], in_data.p0y};
            e1_reg[2] <= {in_data.p1z[23], in_data.p1z} - {in_data.p0z[23], in_data.p0z};
            e2_reg[0] <= {in_data.p2x[23], in_data.p2x} - {in_data.p0x[23], in_data.p0x};
            e2_reg[1] <= {in_data.p2y[23], in_data.p2y} - {in_data.p0y[23], in_data.p0y};
            e2_reg[2] <= {in_data.p2z[23], in_data.p2z} - {in_data.p0z[23], in_data.p0z};
            s1_reg    <= '{idx0: in_data.idx0, idx1: in_data.idx1, idx2: in_data.idx2,
                           neg: 3'b000};
            pr_reg[0] <= e1_reg[1] * e2_reg[2];
            pr_reg[1] <= e1_reg[2] * e2_reg[1];
            pr_reg[2] <= e1_reg[2] * e2_reg[0];
            pr_reg[3] <= e1_reg[0] * e2_reg[2];
            pr_reg[4] <= e1_reg[0] * e2_reg[1];
            pr_reg[5] <= e1_reg[1] * e2_reg[0];
            s2_reg    <= s1_reg;
            s3_reg    <= s3_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = s3_reg;
endmodule

### hw/rtl/tfn_norm.sv
// Common scaling of the three magnitudes and the sum of their squares: four stages.
// Uses tfn_pkg.
module tfn_norm (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  tfn_pkg::mag_t in_data,
    output logic          out_valid,
    output tfn_pkg::sq_t  out_data
);
    localparam int unsigned MW = tfn_pkg::MagW;
    localparam int unsigned NW = tfn_pkg::NormW;
    localparam int unsigned PosW = $clog2(MW);
    localparam logic [PosW-1:0] Target = PosW'(NW - 1);

    tfn_pkg::mag_t       a_reg;
    logic [PosW-1:0]     pos_reg;
    tfn_pkg::side_t      b_side_reg, c_side_reg;
    logic [NW-1:0]       b_m_reg [3];
    logic [2*NW-1:0]     sq_reg [3];
    logic [NW-1:0]       c_m_reg [3];
    tfn_pkg::sq_t        d_reg;
    logic [3:0]          v_reg;
    logic [MW-1:0]       any_bits;
    logic [PosW-1:0]     pos_next;
    logic [MW-1:0]       sh [3];

    // Find the leading one of the largest magnitude
    always_comb
    begin
        any_bits = in_data.m[0] | in_data.m[1] | in_data.m[2];
        pos_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (any_bits[i])
                pos_next = PosW'(i);
        end
    end

    // Bring the leading one to the top bit of the scaled word
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos_reg > Target)
                sh[i] = a_reg.m[i] >> (pos_reg - Target);
            else
                sh[i] = a_reg.m[i] << (Target - pos_reg);
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    // Advance the data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= in_data;
            pos_reg    <= pos_next;
            b_side_reg <= a_reg.side;
            for (int i = 0; i < 3; i++)
            begin
                b_m_reg[i] <= sh[i][NW-1:0];
                sq_reg[i]  <= b_m_reg[i] * b_m_reg[i];
                c_m_reg[i] <= b_m_reg[i];
                d_reg.m[i] <= c_m_reg[i];
            end
            c_side_reg <= b_side_reg;
            d_reg.side <= c_side_reg;
            d_reg.s    <= tfn_pkg::SumW'(sq_reg[0]) + tfn_pkg::SumW'(sq_reg[1])
                        + tfn_pkg::SumW'(sq_reg[2]);
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = d_reg;
endmodule

### hw/rtl/tfn_sqrt.sv
// Integer square root of the sum of squares, one result bit per stage (32 stages).
// Uses tfn_pkg.
module tfn_sqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  tfn_pkg::sq_t  in_data,
    output logic          out_valid,
    output tfn_pkg::len_t out_data
);
    localparam int unsigned Steps = tfn_pkg::LenW;
    localparam int unsigned SW    = tfn_pkg::SumW;

    typedef struct packed {
        tfn_pkg::side_t                         side;
        logic [2:0][tfn_pkg::NormW-1:0]         m;
        logic [SW-1:0]                          rem;
        logic [SW-1:0]                          root;
    } step_t;

    step_t            st_in;
    step_t            st_reg [1:Steps];
    logic [Steps:1]   v_reg;

    // Load the first stage from the incoming transaction
    always_comb
    begin
        st_in.side = in_data.side;
        st_in.m    = in_data.m;
        st_in.rem  = in_data.s;
        st_in.root = '0;
    end

    for (genvar k = 0; k < Steps; k++)
    begin : g_step
        localparam logic [SW-1:0] Bit = SW'(1) << (2 * (Steps - 1 - k));
        step_t         cur;
        logic          cur_v;
        logic [SW-1:0] trial;
        step_t         nxt;

        // Pick the stage input
        if (k == 0)
        begin : g_head
            assign cur   = st_in;
            assign cur_v = in_valid;
        end
        else
        begin : g_body
            assign cur   = st_reg[k];
            assign cur_v = v_reg[k];
        end

        // Try the next root bit, keep it where the remainder allows
        always_comb
        begin
            trial    = cur.root + Bit;
            nxt      = cur;
            if (cur.rem >= trial)
            begin
                nxt.rem  = cur.rem - trial;
                nxt.root = (cur.root >> 1) + Bit;
            end
            else
                nxt.root = cur.root >> 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= cur_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k+1] <= nxt;
        end
    end

    assign out_valid     = v_reg[Steps];
    assign out_data.side = st_reg[Steps].side;
    assign out_data.m    = st_reg[Steps].m;
    assign out_data.len  = st_reg[Steps].root[tfn_pkg::LenW-1:0];
endmodule

### hw/rtl/tfn_div.sv
// Rounded division of the three magnitudes by the length, one quotient bit per stage,
// then clamping, sign and degenerate handling (17 stages). Uses tfn_pkg.
module tfn_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  tfn_pkg::len_t in_data,
    output logic          out_valid,
    output tfn_pkg::res_t out_data
);
    localparam int unsigned QW = tfn_pkg::QuotW;
    localparam int unsigned NW = tfn_pkg::NumW;

    typedef struct packed {
        tfn_pkg::side_t              side;
        logic [tfn_pkg::LenW-1:0]    len;
        logic [2:0][NW-1:0]          rem;
        logic [2:0][QW-1:0]          q;
    } dstep_t;

    dstep_t           st_reg [QW+1];
    logic [QW+2:1]    v_reg;
    tfn_pkg::res_t    res_reg;
    tfn_pkg::res_t    res_next;
    logic [QW-1:0]    mag [3];
    tfn_pkg::nrm_t    val [3];

    // Form the rounded numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].side <= in_data.side;
            st_reg[0].len  <= in_data.len;
            st_reg[0].q    <= '0;
            for (int i = 0; i < 3; i++)
                st_reg[0].rem[i] <= (NW'(in_data.m[i]) << tfn_pkg::FracW)
                                  + NW'(in_data.len >> 1);
        end
    end

    // Advance the valid bits: numerator, quotient bits and result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW+1:1], in_valid};
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int unsigned Sh = QW - 1 - j;
        logic [NW-1:0] dv;
        dstep_t        nxt;

        // Subtract the shifted divisor where it fits
        always_comb
        begin
            dv  = NW'(st_reg[j].len) << Sh;
            nxt = st_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                if (st_reg[j].rem[i] >= dv)
                begin
                    nxt.rem[i]   = st_reg[j].rem[i] - dv;
                    nxt.q[i][Sh] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[j+1] <= nxt;
        end
    end

    // Clamp, apply the sign and zero a degenerate triangle
    always_comb
    begin
        res_next.degenerate = (st_reg[QW].len == '0);
        res_next.idx0       = st_reg[QW].side.idx0;
        res_next.idx1       = st_reg[QW].side.idx1;
        res_next.idx2       = st_reg[QW].side.idx2;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (st_reg[QW].q[i] > tfn_pkg::UnitOne) ? tfn_pkg::UnitOne : st_reg[QW].q[i];
            if (res_next.degenerate)
                val[i] = '0;
            else if (st_reg[QW].side.neg[i])
                val[i] = -tfn_pkg::nrm_t'({1'b0, mag[i]});
            else
                val[i] = tfn_pkg::nrm_t'({1'b0, mag[i]});
        end
        res_next.nx = val[0];
        res_next.ny = val[1];
        res_next.nz = val[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = v_reg[QW+2];
    assign out_data  = res_reg;
endmodule

### hw/rtl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// Uses tfn_pkg, tfn_if, tfn_cross, tfn_norm, tfn_sqrt and tfn_div.
//
// Usage:
//   tri_in carries one triangle per transaction: three Q12.12 vertex positions and
//   three vertex indices. nrm_out returns one transaction per triangle, in order:
//   the unit normal in Q1.14 rounded to nearest, a degenerate flag for a zero-length
//   cross product (normal then zero), and the three indices unchanged.
//   The pipeline has 56 register stages: 3 for the exact cross product, 4 for
//   scaling and sum of squares, 32 for the square root (one root bit per stage)
//   and 17 for the three parallel dividers (a numerator stage, one quotient bit
//   per stage, and a clamp and sign stage).
//   Throughput is one triangle per cycle while nrm_out is taken.
//   The whole pipeline advances together: when a result sits on nrm_out and the
//   receiver holds ready low, every stage holds and tri_in.ready drops; nothing is
//   lost or repeated. Bubbles in the pipeline are not squeezed out during a stall.
//   Reset clears all stage valid bits; the block accepts a triangle as soon as
//   reset is released.
module triangle_face_normal (
    input  logic       clk,
    input  logic       rst_n,
    tfn_tri_if.sink    tri_in,
    tfn_nrm_if.source  nrm_out
);
    logic          en;
    tfn_pkg::tri_t tri_data;
    logic          cr_valid, nm_valid, sq_valid, dv_valid;
    tfn_pkg::mag_t cr_data;
    tfn_pkg::sq_t  nm_data;
    tfn_pkg::len_t sq_data;
    tfn_pkg::res_t dv_data;

    // Advance the pipeline whenever the output stage is free or being taken
    assign en           = !dv_valid || nrm_out.ready;
    assign tri_in.ready = en;

    // Gather the transaction into one word
    always_comb
    begin
        tri_data.p0x  = tri_in.first_x;
        tri_data.p0y  = tri_in.first_y;
        tri_data.p0z  = tri_in.first_z;
        tri_data.p1x  = tri_in.second_x;
        tri_data.p1y  = tri_in.second_y;
        tri_data.p1z  = tri_in.second_z;
        tri_data.p2x  = tri_in.third_x;
        tri_data.p2y  = tri_in.third_y;
        tri_data.p2z  = tri_in.third_z;
        tri_data.idx0 = tri_in.first_index;
        tri_data.idx1 = tri_in.second_index;
        tri_data.idx2 = tri_in.third_index;
    end

    tfn_cross u_cross (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(tri_in.valid), .in_data(tri_data),
        .out_valid(cr_valid), .out_data(cr_data)
    );

    tfn_norm u_norm (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(cr_valid), .in_data(cr_data),
        .out_valid(nm_valid), .out_data(nm_data)
    );

    tfn_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(nm_valid), .in_data(nm_data),
        .out_valid(sq_valid), .out_data(sq_data)
    );

    tfn_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sq_valid), .in_data(sq_data),
        .out_valid(dv_valid), .out_data(dv_data)
    );

    assign nrm_out.valid            = dv_valid;
    assign nrm_out.normal_x         = dv_data.nx;
    assign nrm_out.normal_y         = dv_data.ny;
    assign nrm_out.normal_z         = dv_data.nz;
    assign nrm_out.degenerate       = dv_data.degenerate;
    assign nrm_out.out_first_index  = dv_data.idx0;
    assign nrm_out.out_second_index = dv_data.idx1;
    assign nrm_out.out_third_index  = dv_data.idx2;
endmodule

### hw/rtl/tfn_checker.sv
// Port-level checks for triangle_face_normal and the bind that attaches them.
// Uses tfn_pkg for field types.
module tfn_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input tfn_pkg::nrm_t normal_x,
    input tfn_pkg::nrm_t normal_y,
    input tfn_pkg::nrm_t normal_z,
    input logic          degenerate
);
    // A result held back by the receiver stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    // An empty output stage never blocks the input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // A degenerate triangle gives a zero normal
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate result with non-zero normal");

    // Components stay within the unit range
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
                   && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
                   && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
        else $error("normal component out of unit range");
endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(tri_in.ready),
    .out_valid(nrm_out.valid),
    .out_ready(nrm_out.ready),
    .normal_x(nrm_out.normal_x),
    .normal_y(nrm_out.normal_y),
    .normal_z(nrm_out.normal_z),
    .degenerate(nrm_out.degenerate)
);

### dv/triangle_face_normal_test.sv
// Self-checking testbench for the triangle face normal pipeline.
// Depends on tfn_pkg, tfn_if and triangle_face_normal from hw/rtl.
`timescale 1ns / 100ps

module triangle_face_normal_test;

    localparam int PipeLatency = 56;
    localparam int CycleLimit  = 400000;

    typedef struct {
        tfn_pkg::coord_t p [9];
        tfn_pkg::idx_t   ix [3];
    } tri_item_t;

    typedef struct {
        tfn_pkg::nrm_t n [3];
        logic          degen;
        tfn_pkg::idx_t ix [3];
    } nrm_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   err_count = 0;
    int   cycle_count = 0;
    int   sent = 0;
    int   received = 0;
    int   degen_seen = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_off = 1'b0;

    tfn_tri_if tri_ch ();
    tfn_nrm_if nrm_ch ();

    triangle_face_normal dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tri_in  (tri_ch.sink),
        .nrm_out (nrm_ch.source)
    );

    always #5 clk = ~clk;

    // Print one line per mismatch and count it
    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    // Integer square root, one bit pair per step
    function automatic longint unsigned root64(input longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Compute the expected unit normal of one triangle
    function automatic nrm_item_t face_normal(input tri_item_t t);
        nrm_item_t r;
        longint e1 [3];
        longint e2 [3];
        longint c [3];
        longint unsigned m [3];
        longint unsigned top;
        longint unsigned len;
        longint unsigned q;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'(t.p[3 + i]) - longint'(t.p[i]);
            e2[i] = longint'(t.p[6 + i]) - longint'(t.p[i]);
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 3; i++)
            m[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        r.degen = (top == 0);
        for (int i = 0; i < 3; i++)
            r.ix[i] = t.ix[i];
        if (r.degen)
        begin
            for (int i = 0; i < 3; i++)
                r.n[i] = '0;
            return r;
        end
        while (top >= (64'd1 << 31))
        begin
            top >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (top < (64'd1 << 30))
        begin
            top <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * 64'd16384 + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            r.n[i] = (c[i] < 0) ? tfn_pkg::nrm_t'(-longint'(q)) : tfn_pkg::nrm_t'(q);
        end
        return r;
    endfunction

    // Queue of expected normals, oldest first
    class normal_scoreboard;
        nrm_item_t pending [$];

        function void note_triangle(input tri_item_t t);
            pending.insert(pending.size(), face_normal(t));
        endfunction

        task check_normal(input nrm_item_t got);
            nrm_item_t want;
            if (pending.size() == 0)
            begin
                report("normal with no triangle outstanding");
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++)
            begin
                if (got.n[i] !== want.n[i])
                    report($sformatf("normal[%0d] got %0d want %0d",
                                     i, got.n[i], want.n[i]));
                if (got.ix[i] !== want.ix[i])
                    report($sformatf("index[%0d] got %0h want %0h",
                                     i, got.ix[i], want.ix[i]));
            end
            if (got.degen !== want.degen)
                report($sformatf("degenerate got %b want %b", got.degen, want.degen));
        endtask
    endclass

    normal_scoreboard sb = new();

    // Inputs known from time zero
    initial
    begin
        tri_ch.valid = 1'b0;
        {tri_ch.first_x, tri_ch.first_y, tri_ch.first_z} = '0;
        {tri_ch.second_x, tri_ch.second_y, tri_ch.second_z} = '0;
        {tri_ch.third_x, tri_ch.third_y, tri_ch.third_z} = '0;
        {tri_ch.first_index, tri_ch.second_index, tri_ch.third_index} = '0;
        nrm_ch.ready = 1'b0;
    end

    // Abort on a run that never finishes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, plus the long hold-off when asked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (nrm_ch.valid && nrm_ch.ready)
            begin
                nrm_item_t got;
                got.n[0] = nrm_ch.normal_x;
                got.n[1] = nrm_ch.normal_y;
                got.n[2] = nrm_ch.normal_z;
                got.degen = nrm_ch.degenerate;
                got.ix[0] = nrm_ch.out_first_index;
                got.ix[1] = nrm_ch.out_second_index;
                got.ix[2] = nrm_ch.out_third_index;
                if (got.degen === 1'b1) degen_seen++;
                received++;
                sb.check_normal(got);
            end
            nrm_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one triangle and wait for its transaction
    task automatic send_triangle(input tri_item_t t);
        while ($urandom_range(99) < idle_pct)
        begin
            tri_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.first_x <= t.p[0];
        tri_ch.first_y <= t.p[1];
        tri_ch.first_z <= t.p[2];
        tri_ch.second_x <= t.p[3];
        tri_ch.second_y <= t.p[4];
        tri_ch.second_z <= t.p[5];
        tri_ch.third_x <= t.p[6];
        tri_ch.third_y <= t.p[7];
        tri_ch.third_z <= t.p[8];
        tri_ch.first_index <= t.ix[0];
        tri_ch.second_index <= t.ix[1];
        tri_ch.third_index <= t.ix[2];
        do
            @(posedge clk);
        while (!tri_ch.ready);
        sb.note_triangle(t);
        sent++;
    endtask

    function automatic tfn_pkg::coord_t rand_coord(input int kind);
        case (kind)
            0: return tfn_pkg::coord_t'($urandom);
            1: return tfn_pkg::coord_t'($signed($urandom_range(8191)) - 4096);
            2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            default: return tfn_pkg::coord_t'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic tri_item_t rand_triangle();
        tri_item_t t;
        int kind;
        int shape;
        kind = int'($urandom_range(3));
        shape = int'($urandom_range(19));
        for (int i = 0; i < 9; i++)
            t.p[i] = rand_coord(int'(($urandom_range(7) == 0) ? $urandom_range(3) : kind));
        // Collinear or coincident vertices now and then
        if (shape == 0)
            for (int i = 0; i < 3; i++) t.p[6 + i] = t.p[i];
        else if (shape == 1)
            for (int i = 0; i < 3; i++)
                t.p[6 + i] = tfn_pkg::coord_t'(2 * t.p[3 + i] - t.p[i]);
        else if (shape == 2)
            for (int i = 0; i < 3; i++) t.p[3 + i] = t.p[i];
        // Tiny triangles exercise the scale-up path
        else if (shape == 3)
            for (int i = 3; i < 9; i++)
                t.p[i] = tfn_pkg::coord_t'(t.p[i - 3 * (i / 3)] + int'($urandom_range(2)));
        for (int i = 0; i < 3; i++)
            t.ix[i] = tfn_pkg::idx_t'($urandom);
        return t;
    endfunction

    function automatic tri_item_t make_tri(input tfn_pkg::coord_t a [9],
                                           input tfn_pkg::idx_t i0,
                                           input tfn_pkg::idx_t i1,
                                           input tfn_pkg::idx_t i2);
        tri_item_t t;
        t.p = a;
        t.ix[0] = i0;
        t.ix[1] = i1;
        t.ix[2] = i2;
        return t;
    endfunction

    // Stimulus
    initial
    begin
        tfn_pkg::coord_t mx;
        tfn_pkg::coord_t mn;
        mx = 24'sh7FFFFF;
        mn = 24'sh800000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed triangles: axis faces, extremes, degenerate shapes
        send_triangle(make_tri('{0, 0, 0, 4096, 0, 0, 0, 4096, 0}, 0, 1, 2));
        send_triangle(make_tri('{0, 0, 0, 0, 4096, 0, 4096, 0, 0}, 16'hFFFF, 0, 16'h8000));
        send_triangle(make_tri('{0, 0, 0, 0, 0, 1, 1, 0, 0}, 3, 4, 5));
        send_triangle(make_tri('{5, 5, 5, 5, 5, 5, 5, 5, 5}, 7, 7, 7));
        send_triangle(make_tri('{0, 0, 0, 1, 1, 1, 2, 2, 2}, 1, 2, 3));
        send_triangle(make_tri('{mn, mn, mn, mx, mn, mn, mn, mx, mn}, 16'hAAAA, 16'h5555, 1));
        send_triangle(make_tri('{mx, mx, mx, mn, mx, mx, mx, mn, mx}, 16'h5555, 16'hAAAA, 2));
        send_triangle(make_tri('{mn, mx, mn, mx, mn, mx, mn, mn, mx}, 16'hFFFF, 16'hFFFF, 0));
        send_triangle(make_tri('{mx, mn, 0, mn, mx, 0, mx, mx, mn}, 9, 8, 7));
        send_triangle(make_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 0, 0, 0));
        send_triangle(make_tri('{mn, mn, mn, mx, mx, mx, mn, mn, mn}, 1, 1, 1));
        send_triangle(make_tri('{0, 0, 0, 1, 1, 0, 1, -1, 0}, 2, 2, 2));
        send_triangle(make_tri('{-1, -1, -1, 0, -1, -1, -1, 0, 0}, 4, 5, 6));

        // Random phases with varied idling on each side
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            if (ph == 2)
            begin
                // Long hold-off so the pipeline fills and back-pressures
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (150) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (160)
                send_triangle(rand_triangle());
        end
        tri_ch.valid <= 1'b0;

        // Drain outstanding normals, then allow for the pipeline latency
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (PipeLatency + 10) @(posedge clk);

        $display("sent %0d triangles, checked %0d normals (%0d degenerate)",
                 sent, received, degen_seen);
        $display("phases: free flow, sender gaps, receiver stalls with long hold-off, mixed");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### triangle_face_normal.f
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_if.sv
hw/rtl/tfn_cross.sv
hw/rtl/tfn_norm.sv
hw/rtl/tfn_sqrt.sv
hw/rtl/tfn_div.sv
hw/rtl/triangle_face_normal.sv
hw/rtl/tfn_checker.sv
dv/triangle_face_normal_test.sv
